// ===== src/pth_pkg.sv =====
package pth_pkg;

  localparam int unsigned MulLat = 3;
  localparam int unsigned DivLat = 66;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [31:0] HumMaxQ = 32'sd419430400;
  localparam logic signed [31:0] TempMin = -32'sd4000;
  localparam logic signed [31:0] TempMax = 32'sd8500;
  localparam logic signed [63:0] PressMax = 64'sd33554431;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP  = 3'd0,
    REG_PLO   = 3'd1,
    REG_PHI   = 3'd2,
    REG_MIXED = 3'd3,
    REG_HUM   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } pth_in_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [24:0]        press_frac;
    logic               press_valid;
    logic [16:0]        hum_frac;
  } pth_out_t;

endpackage

// ===== src/pth_delay.sv =====
module pth_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int unsigned i = 1; i < N; i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

// ===== src/pth_mul64.sv =====
module pth_mul64 (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  // low 64 bits of the product; identical for signed and unsigned operands
  logic [63:0] a_q, b_q;
  logic [63:0] ll_d, ll_q;
  logic [31:0] lh_d, lh_q, hl_d, hl_q;
  logic [63:0] p_d, p_q;

  assign ll_d = a_q[31:0] * b_q[31:0];
  assign lh_d = a_q[31:0] * b_q[63:32];
  assign hl_d = a_q[63:32] * b_q[31:0];
  assign p_d  = ll_q + {lh_q + hl_q, 32'b0};

  always_ff @(posedge clk_i) begin
    a_q  <= a_i;
    b_q  <= b_i;
    ll_q <= ll_d;
    lh_q <= lh_d;
    hl_q <= hl_d;
    p_q  <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== src/pth_div.sv =====
module pth_div (
  input  logic        clk_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] quo_o
);

  // signed 64/64 truncating divide, one quotient bit per stage
  logic [63:0] rem_q [65];
  logic [63:0] quo_q [65];
  logic [63:0] den_q [65];
  logic        neg_q [65];
  logic [63:0] res_q;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    quo_q[0] <= num_i[63] ? (~num_i + 64'd1) : num_i;
    den_q[0] <= den_i[63] ? (~den_i + 64'd1) : den_i;
    neg_q[0] <= num_i[63] ^ den_i[63];
  end

  for (genvar k = 0; k < 64; k++) begin : g_step
    logic [64:0] trial;
    logic        fit;

    assign trial = {rem_q[k], quo_q[k][63]} - {1'b0, den_q[k]};
    assign fit   = ~trial[64];

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= fit ? trial[63:0] : {rem_q[k][62:0], quo_q[k][63]};
      quo_q[k+1] <= {quo_q[k][62:0], fit};
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= neg_q[64] ? (~quo_q[64] + 64'd1) : quo_q[64];
  end

  assign quo_o = res_q;

endmodule

// ===== src/pth_sensor_compensation_top.sv =====
// Throughput: one beat per cycle; busy_o stays low and the receiver cannot stall.
// Depth is set by the 64-stage radix-2 pressure divider and the split 64-bit multipliers.
// Reset clears the calibration registers and the valid chain; data stages are not reset.
module pth_sensor_compensation_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  pth_pkg::pth_in_t             in_i,
  input  logic                         cfg_we_i,
  input  logic [pth_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pth_pkg::CfgW-1:0]     cfg_data_i,
  output logic                         done_o,
  output pth_pkg::pth_out_t            res_o
);

  localparam int unsigned Lat = 88;

  logic [47:0] temp_cal_q;
  logic [63:0] plo_cal_q, phi_cal_q;
  logic [47:0] mix_cal_q;
  logic [31:0] hum_cal_q;
  logic [Lat-1:0] vld_q;
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      plo_cal_q  <= '0;
      phi_cal_q  <= '0;
      mix_cal_q  <= '0;
      hum_cal_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pth_pkg::REG_TEMP:  temp_cal_q <= cfg_data_i[47:0];
        pth_pkg::REG_PLO:   plo_cal_q  <= cfg_data_i;
        pth_pkg::REG_PHI:   phi_cal_q  <= cfg_data_i;
        pth_pkg::REG_MIXED: mix_cal_q  <= cfg_data_i[47:0];
        pth_pkg::REG_HUM:   hum_cal_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  // calibration fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_cal_q[15:0];
  assign t2 = $signed(temp_cal_q[31:16]);
  assign t3 = $signed(temp_cal_q[47:32]);
  assign p1 = plo_cal_q[15:0];
  assign p2 = $signed(plo_cal_q[31:16]);
  assign p3 = $signed(plo_cal_q[47:32]);
  assign p4 = $signed(plo_cal_q[63:48]);
  assign p5 = $signed(phi_cal_q[15:0]);
  assign p6 = $signed(phi_cal_q[31:16]);
  assign p7 = $signed(phi_cal_q[47:32]);
  assign p8 = $signed(phi_cal_q[63:48]);
  assign p9 = $signed(mix_cal_q[15:0]);
  assign h1 = mix_cal_q[23:16];
  assign h2 = $signed(mix_cal_q[39:24]);
  assign h3 = mix_cal_q[47:40];
  assign h4 = $signed(hum_cal_q[11:0]);
  assign h5 = $signed(hum_cal_q[23:12]);
  assign h6 = $signed(hum_cal_q[31:24]);

  // stage 0: input beat
  pth_pkg::pth_in_t in_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
  end

  // stages 1..3: fine temperature
  logic signed [17:0] tdiff;
  logic signed [16:0] td;
  logic signed [33:0] ta_full, dd_full;
  logic signed [31:0] ta_q, dd_q, tan_q, bb_q, tfine_q;
  logic signed [31:0] dsh;
  logic signed [47:0] bb_full;
  logic signed [31:0] ta_d, dd_d, tan_d, bb_d, tfine_d;

  assign tdiff   = $signed({1'b0, in_q.raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign td      = $signed({1'b0, in_q.raw_temp[19:4]}) - $signed({1'b0, t1});
  assign ta_full = tdiff * t2;
  assign dd_full = td * td;
  assign ta_d    = ta_full[31:0];
  assign dd_d    = dd_full[31:0];
  assign tan_d   = ta_q >>> 11;
  assign dsh     = dd_q >>> 12;
  assign bb_full = dsh * t3;
  assign bb_d    = bb_full[31:0];
  assign tfine_d = tan_q + (bb_q >>> 14);

  always_ff @(posedge clk_i) begin
    ta_q    <= ta_d;
    dd_q    <= dd_d;
    tan_q   <= tan_d;
    bb_q    <= bb_d;
    tfine_q <= tfine_d;
  end

  // temperature result, stage 4
  logic signed [34:0] tf5;
  logic signed [31:0] tm_sum, tm;
  logic signed [14:0] temp_d, temp_q, temp_dl;

  assign tf5    = tfine_q * 35'sd5;
  assign tm_sum = tf5[31:0] + 32'sd128;
  assign tm     = tm_sum >>> 8;

  always_comb begin
    priority if (tm < pth_pkg::TempMin) begin
      temp_d = 15'(pth_pkg::TempMin);
    end else if (tm > pth_pkg::TempMax) begin
      temp_d = 15'(pth_pkg::TempMax);
    end else begin
      temp_d = tm[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
  end

  pth_delay #(.W(15), .N(82)) u_temp_dl (
    .clk_i(clk_i), .d_i(temp_q), .q_o(temp_dl)
  );

  // humidity, stages 4..11
  logic [15:0] raw_hum4;
  logic signed [31:0] hx_d, hx_q;
  logic [31:0] hs, h4s;
  logic signed [43:0] h5x;
  logic signed [39:0] bm_full, dm_full;
  logic signed [31:0] apre_d, apre_q, bm_q, dm_q;
  logic signed [31:0] ha_s, ha_d, ha_q, ha2_q;
  logic signed [31:0] b0, dd2;
  logic signed [63:0] bd_full;
  logic signed [31:0] bd_q, hb0, hbs;
  logic signed [47:0] hbm_full;
  logic signed [31:0] hbm_q, hbt, hb;
  logic signed [63:0] hxv_full, yy_full;
  logic signed [31:0] hxv_q, hxv2_q, hxv3_q, hy, yy_q, ys;
  logic signed [40:0] m_full;
  logic signed [31:0] m_q, hr;
  logic signed [31:0] hcl;
  logic [16:0] hum_d, hum_q, hum_dl;

  pth_delay #(.W(16), .N(4)) u_hum_dl_in (
    .clk_i(clk_i), .d_i(in_q.raw_hum), .q_o(raw_hum4)
  );

  assign hx_d     = tfine_q - 32'sd76800;
  assign hs       = {2'b0, raw_hum4, 14'b0};
  assign h4s      = {h4, 20'b0};
  assign h5x      = h5 * hx_q;
  assign apre_d   = hs - h4s - h5x[31:0];
  assign bm_full  = hx_q * h6;
  assign dm_full  = hx_q * $signed({1'b0, h3});
  assign ha_s     = apre_q + 32'sd16384;
  assign ha_d     = ha_s >>> 15;
  assign b0       = bm_q >>> 10;
  assign dd2      = (dm_q >>> 11) + 32'sd32768;
  assign bd_full  = b0 * dd2;
  assign hb0      = bd_q >>> 10;
  assign hbs      = hb0 + 32'sd2097152;
  assign hbm_full = hbs * h2;
  assign hbt      = hbm_q + 32'sd8192;
  assign hb       = hbt >>> 14;
  assign hxv_full = ha2_q * hb;
  assign hy       = hxv_q >>> 15;
  assign yy_full  = hy * hy;
  assign ys       = yy_q >>> 7;
  assign m_full   = ys * $signed({1'b0, h1});
  assign hr       = hxv3_q - (m_q >>> 4);

  always_comb begin
    priority if (hr < 32'sd0) begin
      hcl = 32'sd0;
    end else if (hr > pth_pkg::HumMaxQ) begin
      hcl = pth_pkg::HumMaxQ;
    end else begin
      hcl = hr;
    end
    hum_d = hcl[28:12];
  end

  always_ff @(posedge clk_i) begin
    hx_q   <= hx_d;
    apre_q <= apre_d;
    bm_q   <= bm_full[31:0];
    dm_q   <= dm_full[31:0];
    ha_q   <= ha_d;
    bd_q   <= bd_full[31:0];
    ha2_q  <= ha_q;
    hbm_q  <= hbm_full[31:0];
    hxv_q  <= hxv_full[31:0];
    yy_q   <= yy_full[31:0];
    hxv2_q <= hxv_q;
    m_q    <= m_full[31:0];
    hxv3_q <= hxv2_q;
    hum_q  <= hum_d;
  end

  pth_delay #(.W(17), .N(75)) u_hum_dl (
    .clk_i(clk_i), .d_i(hum_q), .q_o(hum_dl)
  );

  // pressure, stages 3..86
  logic [19:0] raw_press10;
  logic signed [63:0] ap;
  logic [63:0] aa6, ap5_6, ap2_6, ap5_9, ap2_9, b1_9, c1_9;
  logic signed [63:0] bsum_d, bsum_q, asum_d, asum_q;
  logic signed [63:0] pz, nn;
  logic [63:0] a3_13, num_13, quo_79;
  logic signed [63:0] den, q79, x79;
  logic [63:0] x82, p9x82, z82, p9xx85, z85, q85;
  logic signed [63:0] y85s, z85s, q85s, psum, pr_d, pr_q;
  logic zero_13, zero_dl;
  logic [24:0] press_sat;

  pth_delay #(.W(20), .N(10)) u_press_dl_in (
    .clk_i(clk_i), .d_i(in_q.raw_press), .q_o(raw_press10)
  );

  assign ap = 64'(tfine_q) - 64'sd128000;

  pth_mul64 u_mul_aa  (.clk_i(clk_i), .a_i(ap), .b_i(ap),          .p_o(aa6));
  pth_mul64 u_mul_ap5 (.clk_i(clk_i), .a_i(ap), .b_i(64'(p5)),     .p_o(ap5_6));
  pth_mul64 u_mul_ap2 (.clk_i(clk_i), .a_i(ap), .b_i(64'(p2)),     .p_o(ap2_6));
  pth_mul64 u_mul_b1  (.clk_i(clk_i), .a_i(aa6), .b_i(64'(p6)),    .p_o(b1_9));
  pth_mul64 u_mul_c1  (.clk_i(clk_i), .a_i(aa6), .b_i(64'(p3)),    .p_o(c1_9));

  pth_delay #(.W(64), .N(3)) u_ap5_dl (.clk_i(clk_i), .d_i(ap5_6), .q_o(ap5_9));
  pth_delay #(.W(64), .N(3)) u_ap2_dl (.clk_i(clk_i), .d_i(ap2_6), .q_o(ap2_9));

  assign bsum_d = $signed(b1_9) + $signed({ap5_9[46:0], 17'b0})
                + $signed({{13{p4[15]}}, p4, 35'b0});
  assign asum_d = 64'sd140737488355328 + ($signed(c1_9) >>> 8)
                + $signed({ap2_9[51:0], 12'b0});

  always_ff @(posedge clk_i) begin
    bsum_q <= bsum_d;
    asum_q <= asum_d;
  end

  assign pz = 64'sd1048576 - $signed({44'b0, raw_press10});
  assign nn = $signed({pz[32:0], 31'b0}) - bsum_q;

  pth_mul64 u_mul_a3  (.clk_i(clk_i), .a_i(asum_q), .b_i({48'b0, p1}), .p_o(a3_13));
  pth_mul64 u_mul_num (.clk_i(clk_i), .a_i(nn), .b_i(64'd3125),       .p_o(num_13));

  assign den     = $signed(a3_13) >>> 33;
  assign zero_13 = (den == 64'sd0);

  pth_delay #(.W(1), .N(73)) u_zero_dl (.clk_i(clk_i), .d_i(zero_13), .q_o(zero_dl));

  pth_div u_div (.clk_i(clk_i), .num_i(num_13), .den_i(den), .quo_o(quo_79));

  assign q79 = $signed(quo_79);
  assign x79 = q79 >>> 13;

  pth_mul64 u_mul_p9x (.clk_i(clk_i), .a_i(64'(p9)), .b_i(x79), .p_o(p9x82));
  pth_mul64 u_mul_z   (.clk_i(clk_i), .a_i(64'(p8)), .b_i(q79), .p_o(z82));
  pth_delay #(.W(64), .N(3)) u_x_dl (.clk_i(clk_i), .d_i(x79), .q_o(x82));
  pth_mul64 u_mul_p9xx (.clk_i(clk_i), .a_i(p9x82), .b_i(x82), .p_o(p9xx85));
  pth_delay #(.W(64), .N(3)) u_z_dl (.clk_i(clk_i), .d_i(z82), .q_o(z85));
  pth_delay #(.W(64), .N(6)) u_q_dl (.clk_i(clk_i), .d_i(quo_79), .q_o(q85));

  assign y85s = $signed(p9xx85) >>> 25;
  assign z85s = $signed(z85) >>> 19;
  assign q85s = $signed(q85);
  assign psum = q85s + y85s + z85s;
  assign pr_d = (psum >>> 8) + $signed({{44{p7[15]}}, p7, 4'b0});

  always_ff @(posedge clk_i) begin
    pr_q <= pr_d;
  end

  always_comb begin
    priority if (pr_q < 64'sd0) begin
      press_sat = '0;
    end else if (pr_q > pth_pkg::PressMax) begin
      press_sat = '1;
    end else begin
      press_sat = pr_q[24:0];
    end
  end

  // stage 87: result beat
  pth_pkg::pth_out_t res_d, res_q;

  always_comb begin
    res_d.temp_centi  = temp_dl;
    res_d.press_frac  = zero_dl ? '0 : press_sat;
    res_d.press_valid = ~zero_dl;
    res_d.hum_frac    = hum_dl;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = vld_q[Lat-1];
  assign res_o  = res_q;

endmodule

// ===== bench/pth_sensor_compensation_checker.sv =====
`timescale 1ns / 1ps

module pth_sensor_compensation_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  pth_pkg::pth_in_t             in_i,
  input  logic                         cfg_we_i,
  input  logic [pth_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pth_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         done_i,
  input  pth_pkg::pth_out_t            res_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           checked_o
);
  import pth_pkg::*;

  logic [63:0] temp_cal, plo_cal, phi_cal, mix_cal, hum_cal;
  pth_out_t    expected_q[$];

  function automatic longint sfield(logic [63:0] v, int pos, int bits);
    logic [63:0] f;
    f = (v >> pos) & ((64'd1 << bits) - 1);
    if (f[bits-1]) f = f - (64'd1 << bits);
    return longint'(f);
  endfunction

  function automatic longint ufield(logic [63:0] v, int pos, int bits);
    return longint'((v >> pos) & ((64'd1 << bits) - 1));
  endfunction

  function automatic longint w32(longint v);
    int s;
    s = int'(v);
    return longint'(s);
  endfunction

  function automatic pth_out_t compensate(pth_in_t s);
    longint adc_t, adc_p, adc_h;
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint h1, h2, h3, h4, h5, h6;
    longint a, b, d, tfine, tc, pr, x, y, z, num;
    logic   ok;
    pth_out_t r;
    adc_t = s.raw_temp;
    adc_p = s.raw_press;
    adc_h = s.raw_hum;
    t1 = ufield(temp_cal, 0, 16); t2 = sfield(temp_cal, 16, 16);
    t3 = sfield(temp_cal, 32, 16);
    p1 = ufield(plo_cal, 0, 16); p2 = sfield(plo_cal, 16, 16);
    p3 = sfield(plo_cal, 32, 16); p4 = sfield(plo_cal, 48, 16);
    p5 = sfield(phi_cal, 0, 16); p6 = sfield(phi_cal, 16, 16);
    p7 = sfield(phi_cal, 32, 16); p8 = sfield(phi_cal, 48, 16);
    p9 = sfield(mix_cal, 0, 16); h1 = ufield(mix_cal, 16, 8);
    h2 = sfield(mix_cal, 24, 16); h3 = ufield(mix_cal, 40, 8);
    h4 = sfield(hum_cal, 0, 12); h5 = sfield(hum_cal, 12, 12);
    h6 = sfield(hum_cal, 24, 8);

    a = w32(w32(w32((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11);
    d = (adc_t >>> 4) - t1;
    b = w32(w32(w32(w32(d * d) >>> 12) * t3) >>> 14);
    tfine = w32(a + b);
    tc = w32(w32(tfine * 5) + 128) >>> 8;
    if (tc < -4000) tc = -4000;
    if (tc > 8500) tc = 8500;

    a = tfine - 128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((longint'(1) <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      ok = 1'b0;
      pr = 0;
    end else begin
      ok = 1'b1;
      pr = 1048576 - adc_p;
      num = ((pr <<< 31) - b) * 3125;
      if (num == 64'sh8000000000000000 && a == -1) pr = num;
      else pr = num / a;
      x = pr >>> 13;
      y = (p9 * x * x) >>> 25;
      z = (p8 * pr) >>> 19;
      pr = ((pr + y + z) >>> 8) + (p7 <<< 4);
      if (pr < 0) pr = 0;
      if (pr > 33554431) pr = 33554431;
    end

    x = w32(tfine - 76800);
    a = w32(w32(w32(adc_h <<< 14) - w32(h4 <<< 20)) - w32(h5 * x));
    a = w32(a + 16384) >>> 15;
    b = w32(x * h6) >>> 10;
    d = w32((w32(x * h3) >>> 11) + 32768);
    b = w32(b * d) >>> 10;
    b = w32(w32(w32(b + 2097152) * h2) + 8192) >>> 14;
    x = w32(a * b);
    y = x >>> 15;
    x = w32(x - (w32((w32(y * y) >>> 7) * h1) >>> 4));
    if (x < 0) x = 0;
    if (x > 419430400) x = 419430400;

    r.temp_centi  = tc[14:0];
    r.press_frac  = pr[24:0];
    r.press_valid = ok;
    r.hum_frac    = x[28:12];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    checked_o = 0;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pth_out_t e;
    if (!rst_ni) begin
      temp_cal <= '0; plo_cal <= '0; phi_cal <= '0; mix_cal <= '0; hum_cal <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_TEMP:  temp_cal <= cfg_data_i & 64'hFFFF_FFFF_FFFF;
          REG_PLO:   plo_cal  <= cfg_data_i;
          REG_PHI:   phi_cal  <= cfg_data_i;
          REG_MIXED: mix_cal  <= cfg_data_i & 64'hFFFF_FFFF_FFFF;
          REG_HUM:   hum_cal  <= cfg_data_i & 64'hFFFF_FFFF;
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_q.push_back(compensate(in_i));
      if (done_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          e = expected_q.pop_front();
          checked_o++;
          if (res_i.temp_centi !== e.temp_centi)
            report("temp_centi", res_i.temp_centi, e.temp_centi);
          if (res_i.press_frac !== e.press_frac)
            report("press_frac", res_i.press_frac, e.press_frac);
          if (res_i.press_valid !== e.press_valid)
            report("press_valid", res_i.press_valid, e.press_valid);
          if (res_i.hum_frac !== e.hum_frac)
            report("hum_frac", res_i.hum_frac, e.hum_frac);
        end
      end
    end
  end
endmodule

// ===== bench/pth_sensor_compensation_top_tb.sv =====
`timescale 1ns / 1ps

module pth_sensor_compensation_top_tb;
  import pth_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  pth_in_t     sample = '0;
  logic        cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  logic        done;
  pth_out_t    res;
  int          errors, pending, checked;
  int          cycles = 0;
  int          idle_pct = 0;

  localparam int Drain = 120;
  localparam int CycleLimit = 400000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  pth_sensor_compensation_top dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .in_i(sample),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .done_o(done), .res_o(res)
  );

  pth_sensor_compensation_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .in_i(sample),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .done_i(done), .res_i(res), .errors_o(errors), .pending_o(pending),
    .checked_o(checked)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  // typical factory calibration words
  task automatic load_factory();
    write_reg(REG_TEMP,  64'({16'sd50, 16'sd26435, 16'd27504}));
    write_reg(REG_PLO,   {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477});
    write_reg(REG_PHI,   {-16'sd7, 16'sd15500, -16'sd7, 16'sd140});
    write_reg(REG_MIXED, 64'({8'd0, 16'sd359, 8'd75, 16'sd4000}));
    write_reg(REG_HUM,   64'({8'sd30, 12'sd50, 12'sd340}));
  endtask

  // start stays high after the beat; the next send or settle drives it
  task automatic send(pth_in_t s);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_typical(int n);
    pth_in_t s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) begin
        s.raw_temp  = 20'(20'd519888 + $urandom_range(200000) - 100000);
        s.raw_press = 20'(20'd415148 + $urandom_range(200000) - 100000);
        s.raw_hum   = 16'($urandom_range(65535));
      end else begin
        s = pth_in_t'(56'({$urandom(), $urandom()}));
      end
      send(s);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero calibration: divisor zero path
    send('0);
    send('1);
    settle();
    load_factory();
    send('0);
    send('1);
    send({20'd519888, 20'd415148, 16'd0});
    send({20'd519888, 20'd415148, 16'hFFFF});
    send({20'hFFFFF, 20'd0, 16'h8000});
    send({20'd0, 20'hFFFFF, 16'h7FFF});
    send({20'd300000, 20'd300000, 16'd30000});
    settle();

    // extreme calibrations
    write_reg(REG_TEMP, '1);
    write_reg(REG_PLO, '1);
    write_reg(REG_PHI, '1);
    write_reg(REG_MIXED, '1);
    write_reg(REG_HUM, '1);
    send('1);
    send('0);
    send({20'h55555, 20'hAAAAA, 16'h5A5A});
    settle();
    write_reg(REG_PLO, {48'h0, 16'hFFFF});
    write_reg(REG_PHI, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_MIXED, 64'({8'hFF, 16'h8000, 8'hFF, 16'h8000}));
    write_reg(REG_HUM, 64'hFFFF_FFFF_8008_0800);
    send({20'hAAAAA, 20'h55555, 16'hA5A5});
    send('1);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 54 : 0;
      load_factory();
      send_typical(110);
      settle();
      write_reg(REG_TEMP, rand64());
      write_reg(REG_PLO, rand64());
      write_reg(REG_PHI, rand64());
      write_reg(REG_MIXED, rand64());
      write_reg(REG_HUM, rand64());
      send_typical(40);
      settle();
    end

    $display("Checked %0d compensated samples over factory, extreme and random calibrations,",
             checked);
    $display("with and without input gaps.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/pth_pkg.sv
src/pth_delay.sv
src/pth_mul64.sv
src/pth_div.sv
src/pth_sensor_compensation_top.sv
bench/pth_sensor_compensation_checker.sv
bench/pth_sensor_compensation_top_tb.sv
